// ===== design/bhd_pkg.sv =====
// Package for the BER header decoder: parse phases, status codes,
// register index and the result record. No dependencies.
`default_nettype none

package bhd_pkg;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_TAG  = 2'd1,
        PH_LEN  = 2'd2,
        PH_LENX = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_TAGLONG = 2'd2,
        ST_LENLONG = 2'd3
    } t_status;

    // register index of max_length_octets
    localparam logic REG_MAX_LEN_OCTETS = 1'b0;
    localparam logic [2:0] MAX_LEN_OCTETS_RST = 3'd4;
    // hard limit on long-form length octets
    localparam logic [6:0] LEN_OCTETS_LIMIT = 7'd4;
    // result queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [1:0]  tag_class;
        logic        constructed;
        logic [27:0] tag_number;
        logic [31:0] content_length;
        logic        indefinite;
        logic        end_of_contents;
        logic [3:0]  header_octets;
        t_status     status;
    } t_result;

endpackage

`default_nettype wire

// ===== design/bhd_parser.sv =====
// Front end: octet-at-a-time BER header parser. Emits one t_result per
// finished or aborted header. Depends on bhd_pkg.
`default_nettype none

module bhd_parser
    import bhd_pkg::*;
#(
    parameter int TAG_OCTETS_MAX = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic [2:0] i_max_len,
    output logic            o_emit,
    output t_result         o_result
);

    localparam int TCW = $clog2(TAG_OCTETS_MAX + 1);

    t_phase         r_phase, n_phase;
    logic [1:0]     r_class, n_class;
    logic           r_cons, n_cons;
    logic [27:0]    r_tag, n_tag;
    logic [TCW-1:0] r_tcnt, n_tcnt;
    logic [31:0]    r_len, n_len;
    logic [2:0]     r_left, n_left;
    logic [3:0]     r_seen, n_seen;
    logic           r_idz, n_idz;

    t_phase         w_phase;
    logic [1:0]     w_class;
    logic           w_cons;
    logic [27:0]    w_tag;
    logic [TCW-1:0] w_tcnt;
    logic [31:0]    w_len;
    logic [2:0]     w_left;
    logic           w_idz;
    logic [3:0]     seen_inc;
    logic           emit;
    t_status        st;
    logic [31:0]    rlen;
    logic           rind, reoc;

    always_comb begin
        w_phase  = r_phase;
        w_class  = r_class;
        w_cons   = r_cons;
        w_tag    = r_tag;
        w_tcnt   = r_tcnt;
        w_len    = r_len;
        w_left   = r_left;
        w_idz    = r_idz;
        emit     = 1'b0;
        st       = ST_OK;
        rlen     = 32'd0;
        rind     = 1'b0;
        reoc     = 1'b0;
        seen_inc = (r_seen == 4'hF) ? r_seen : r_seen + 4'd1;

        unique case (r_phase)
            PH_ID: begin
                w_class = i_byte[7:6];
                w_cons  = i_byte[5];
                w_idz   = (i_byte == 8'h00);
                if (i_byte[4:0] == 5'd31) begin
                    w_tag   = 28'd0;
                    w_tcnt  = '0;
                    w_phase = PH_TAG;
                end else begin
                    w_tag   = {23'd0, i_byte[4:0]};
                    w_phase = PH_LEN;
                end
            end
            PH_TAG: begin
                if (r_tcnt >= TCW'(TAG_OCTETS_MAX) || r_tag[27:21] != 7'd0) begin
                    emit = 1'b1;
                    st   = ST_TAGLONG;
                end else begin
                    w_tcnt = r_tcnt + TCW'(1);
                    w_tag  = {r_tag[20:0], i_byte[6:0]};
                    if (!i_byte[7]) begin
                        w_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (i_byte == 8'h80) begin
                    emit = 1'b1;
                    rind = 1'b1;
                end else if (!i_byte[7]) begin
                    emit = 1'b1;
                    rlen = {24'd0, i_byte};
                    reoc = r_idz && (i_byte == 8'h00);
                end else if (i_byte[6:0] > {4'd0, i_max_len}
                             || i_byte[6:0] > LEN_OCTETS_LIMIT) begin
                    emit = 1'b1;
                    st   = ST_LENLONG;
                end else begin
                    w_len   = 32'd0;
                    w_left  = i_byte[2:0];
                    w_phase = PH_LENX;
                end
            end
            PH_LENX: begin
                w_len  = {r_len[23:0], i_byte};
                w_left = (r_left != 3'd0) ? r_left - 3'd1 : 3'd0;
                if (w_left == 3'd0) begin
                    emit = 1'b1;
                    rlen = w_len;
                end
            end
            default: begin
                w_phase = PH_ID;
            end
        endcase

        // region ended mid-header
        if (!emit && i_last) begin
            emit = 1'b1;
            st   = ST_TRUNC;
        end

        o_emit                   = i_valid && emit;
        o_result.tag_class       = w_class;
        o_result.constructed     = w_cons;
        o_result.tag_number      = w_tag;
        o_result.content_length  = rlen;
        o_result.indefinite      = rind;
        o_result.end_of_contents = reoc;
        o_result.header_octets   = seen_inc;
        o_result.status          = st;

        n_phase = r_phase;
        n_class = r_class;
        n_cons  = r_cons;
        n_tag   = r_tag;
        n_tcnt  = r_tcnt;
        n_len   = r_len;
        n_left  = r_left;
        n_seen  = r_seen;
        n_idz   = r_idz;
        if (i_valid) begin
            if (emit) begin
                n_phase = PH_ID;
                n_class = 2'd0;
                n_cons  = 1'b0;
                n_tag   = 28'd0;
                n_tcnt  = '0;
                n_len   = 32'd0;
                n_left  = 3'd0;
                n_seen  = 4'd0;
                n_idz   = 1'b0;
            end else begin
                n_phase = w_phase;
                n_class = w_class;
                n_cons  = w_cons;
                n_tag   = w_tag;
                n_tcnt  = w_tcnt;
                n_len   = w_len;
                n_left  = w_left;
                n_seen  = seen_inc;
                n_idz   = w_idz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID;
            r_class <= 2'd0;
            r_cons  <= 1'b0;
            r_tag   <= 28'd0;
            r_tcnt  <= '0;
            r_len   <= 32'd0;
            r_left  <= 3'd0;
            r_seen  <= 4'd0;
            r_idz   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_class <= n_class;
            r_cons  <= n_cons;
            r_tag   <= n_tag;
            r_tcnt  <= n_tcnt;
            r_len   <= n_len;
            r_left  <= n_left;
            r_seen  <= n_seen;
            r_idz   <= n_idz;
        end
    end

endmodule

`default_nettype wire

// ===== design/bhd_fifo.sv =====
// Back end: small result queue between parser and output ports.
// Depends on bhd_pkg.
`default_nettype none

module bhd_fifo
    import bhd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_result   i_wdata,
    input  wire logic i_rd,
    output t_result   o_rdata,
    output logic      o_empty,
    output logic      o_full
);

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QPTR_W:0]    r_count;
    logic               do_wr, do_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ber_header_decoder.sv =====
// BER header decoder top level: one header octet per cycle in while full is low; a
// result is on the ports the cycle after the octet that finishes or aborts a header if the
// result queue was empty, else once the results ahead of it are popped. Throughput: one
// octet per cycle while full is low; full rises only once the four-entry result queue is full and unread.
// Reset (synchronous, active low): queue empty, parser expects an identifier,
// max_length_octets = 4. Depends on bhd_pkg, bhd_parser, bhd_fifo.
`default_nettype none

module ber_header_decoder
    import bhd_pkg::*;
#(
    parameter int TAG_OCTETS_MAX = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // octet input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_region,
    // result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_tag_class,
    output logic             o_constructed,
    output logic [27:0]      o_tag_number,
    output logic [31:0]      o_content_length,
    output logic             o_indefinite,
    output logic             o_end_of_contents,
    output logic [3:0]       o_header_octets,
    output logic [1:0]       o_status,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [2:0] r_max_len;
    logic       in_req;
    logic       emit;
    t_result    parsed;
    t_result    head;

    // --- configuration register --------------------------------------
    // one register, 3 bits in a 32-bit word, at byte address 0; paddr[2] selects the index
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_OCTETS_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LEN_OCTETS) begin
            r_max_len <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_LEN_OCTETS) ? {29'd0, r_max_len} : 32'd0;

    // --- front: octet parser -----------------------------------------
    // a request is taken whenever the queue has room for its possible result
    assign in_req = push && !full;

    bhd_parser #(
        .TAG_OCTETS_MAX (TAG_OCTETS_MAX)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_req),
        .i_byte    (i_in_byte),
        .i_last    (i_end_of_region),
        .i_max_len (r_max_len),
        .o_emit    (emit),
        .o_result  (parsed)
    );

    // --- back: result queue drives the output ports -------------------
    bhd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (emit),
        .i_wdata (parsed),
        .i_rd    (pop),
        .o_rdata (head),
        .o_empty (empty),
        .o_full  (full)
    );

    assign o_tag_class       = head.tag_class;
    assign o_constructed     = head.constructed;
    assign o_tag_number      = head.tag_number;
    assign o_content_length  = head.content_length;
    assign o_indefinite      = head.indefinite;
    assign o_end_of_contents = head.end_of_contents;
    assign o_header_octets   = head.header_octets;
    assign o_status          = head.status;

endmodule

`default_nettype wire

// ===== design/bhd_checker.sv =====
// Port-level checks for ber_header_decoder, bound to the top level.
// Depends on bhd_pkg and ber_header_decoder.
`default_nettype none

module bhd_checker
    import bhd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic [31:0] o_content_length,
    input wire logic        o_indefinite,
    input wire logic        o_end_of_contents,
    input wire logic [3:0]  o_header_octets,
    input wire logic [1:0]  o_status
);

    // no result appears without an accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without a request");

    // queue cannot fill without an accepted request
    a_full_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a request");

    // errored or indefinite headers carry no length and no end-of-contents flag
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_indefinite || o_status != ST_OK)) |->
            (o_content_length == 32'd0 && !o_end_of_contents))
        else $error("length set on indefinite or errored header");

    // every header consumes at least one octet
    a_octets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_header_octets != 4'd0))
        else $error("zero header octet count");

    // queue is empty right after reset
    a_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("queue not empty after reset");

endmodule

bind ber_header_decoder bhd_checker u_bhd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .push              (push),
    .full              (full),
    .empty             (empty),
    .o_content_length  (o_content_length),
    .o_indefinite      (o_indefinite),
    .o_end_of_contents (o_end_of_contents),
    .o_header_octets   (o_header_octets),
    .o_status          (o_status)
);

`default_nettype wire
